// ===== src/fsa_pkg.sv =====
// Shared constants and operation codes for the four-state ALU.
// No dependencies.
package fsa_pkg;
	localparam int DATA_WIDTH_DEF = 64;
	localparam int FW = 5;
	localparam int WW = 7;

	typedef enum logic [FW-1:0] {
		OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
		OP_NEG = 5'd5, OP_AND = 5'd6, OP_OR = 5'd7, OP_XOR = 5'd8, OP_NOT = 5'd9,
		OP_EQ = 5'd10, OP_NEQ = 5'd11, OP_LT = 5'd12, OP_GT = 5'd13, OP_LTE = 5'd14,
		OP_GTE = 5'd15, OP_LAND = 5'd16, OP_LOR = 5'd17, OP_LNOT = 5'd18,
		OP_SHL = 5'd19, OP_SHR = 5'd20, OP_ASHR = 5'd21, OP_ZEXT = 5'd22,
		OP_SEXT = 5'd23
	} op_t;
endpackage

// ===== src/fsa_if.sv =====
// Valid/ready channel interface carrying a payload of parameterized width.
// Depends on nothing.
interface fsa_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/fsa_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on fsa_pkg.
module fsa_div import fsa_pkg::*; #(
	parameter int DW = DATA_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [DW-1:0] quo,
	output logic [DW-1:0] rem
);
	logic [DW-1:0] n_q [DW+1];
	logic [DW-1:0] d_q [DW];
	logic [DW-1:0] r_q [DW+1];

	always_comb begin
		n_q[0] = num;
		d_q[0] = den;
		r_q[0] = '0;
	end

	for (genvar i = 0; i < DW; i++) begin : g_st
		logic [DW:0] tr;
		logic [DW:0] df;
		assign tr = {r_q[i], n_q[i][DW-1]};
		assign df = tr - {1'b0, d_q[i]};
		// The last stage has no use for the divisor, so it is not carried further.
		if (i < DW - 1) begin : g_d
			always_ff @(posedge clk) begin
				if (en) d_q[i+1] <= d_q[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!df[DW]) begin
					r_q[i+1] <= df[DW-1:0];
					n_q[i+1] <= {n_q[i][DW-2:0], 1'b1};
				end else begin
					r_q[i+1] <= tr[DW-1:0];
					n_q[i+1] <= {n_q[i][DW-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = n_q[DW];
	assign rem = r_q[DW];
endmodule

// ===== src/four_state_alu.sv =====
// Four-state ALU top level: decode, arithmetic and bitwise result pipeline.
// Depends on fsa_pkg, fsa_if and fsa_div.
//
//  channel  dir  payload
//  in       sink {func, a_val,a_x,a_z,a_width, b_val,b_x,b_z,b_width}
//  out      src  {r_val, r_x, r_z, r_width}
//
// One item per cycle while the output stage is free or taken. The pipeline depth is
// set by the divider, which takes one quotient bit per stage; all ops
// flow through every stage.
// The whole pipeline advances together when the output stage is free or taken,
// so a stall freezes every stage and nothing is lost or repeated.
// Reset clears only the valid bits.
module four_state_alu import fsa_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	fsa_if.sink   in,
	fsa_if.source out
);
	localparam int DW = DATA_WIDTH;
	localparam int LAT = DW;

	typedef struct packed {
		logic [FW-1:0] func;
		logic [DW-1:0] a_val, a_x, a_z;
		logic [WW-1:0] a_width;
		logic [DW-1:0] b_val, b_x, b_z;
		logic [WW-1:0] b_width;
	} req_t;

	typedef struct packed {
		logic [DW-1:0] r_val, r_x, r_z;
		logic [WW-1:0] r_width;
	} res_t;

	// result of stage 1 for everything except mul, div and mod
	typedef struct packed {
		logic          isdiv;
		logic          ismod;
		logic          dbad;
		logic          ext;
		logic [DW-1:0] m;
		logic [DW-1:0] v, x, z;
		logic [WW-1:0] w;
	} s1_t;

	req_t req;
	assign req = in.data;

	logic adv;
	logic [LAT:0] vld_q;
	res_t out_q;

	assign adv = !vld_q[LAT] || out.ready;
	assign in.ready = adv;
	assign out.valid = vld_q[LAT];
	assign out.data = out_q;

	function automatic logic [DW-1:0] wm(input logic [WW-1:0] w);
		logic [DW-1:0] r;
		r = '0;
		for (int i = 0; i < DW; i++) r[i] = (i < int'(w));
		return r;
	endfunction

	function automatic logic [WW-1:0] clampw(input logic [WW-1:0] w);
		if (w == '0) return WW'(1);
		if (w > WW'(DW)) return WW'(DW);
		return w;
	endfunction

	// ---- stage 0 combinational: clamp, mask, most ops
	logic [WW-1:0] aw, bw, mw;
	logic [DW-1:0] am, bm;
	logic [DW-1:0] av, ax, az, bv, bx, bz, axz, bxz;
	logic abad, bbad, bad;
	s1_t s0;
	logic [DW-1:0] mul_a, mul_b;

	always_comb begin
		logic [DW-1:0] f0, f1, rx, ext;
		logic sgn;
		int sh;
		aw = clampw(req.a_width);
		bw = clampw(req.b_width);
		mw = (aw > bw) ? aw : bw;
		am = wm(aw);
		bm = wm(bw);
		av = req.a_val & am; ax = req.a_x & am; az = req.a_z & am;
		bv = req.b_val & bm; bx = req.b_x & bm; bz = req.b_z & bm;
		axz = ax | az; bxz = bx | bz;
		abad = |axz; bbad = |bxz; bad = abad | bbad;
		sgn = av[aw - 1];
		sh = int'(bv[WW-1:0]);
		mul_a = av; mul_b = bv;
		s0 = '0;
		s0.x = '1;
		s0.w = aw;
		f0 = '0; f1 = '0; rx = '0; ext = '0;
		case (req.func)
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
				s0.w = mw;
				s0.x = bad ? '1 : '0;
				if (req.func == OP_ADD) s0.v = av + bv;
				if (req.func == OP_SUB) s0.v = av - bv;
				s0.isdiv = (req.func == OP_DIV);
				s0.ismod = (req.func == OP_MOD);
				s0.dbad = bad || (bv == '0);
			end
			OP_NEG: begin
				s0.x = abad ? '1 : '0;
				s0.v = ~av + 1'b1;
			end
			OP_AND: begin
				f0 = (~av & ~axz) | (~bv & ~bxz);
				rx = (axz | bxz) & ~f0;
				s0.v = av & bv & ~rx; s0.x = rx; s0.w = mw;
			end
			OP_OR: begin
				f1 = (av & ~axz) | (bv & ~bxz);
				rx = (axz | bxz) & ~f1;
				s0.v = (av | bv | f1) & ~rx; s0.x = rx; s0.w = mw;
			end
			OP_XOR: begin
				rx = axz | bxz;
				s0.v = (av ^ bv) & ~rx; s0.x = rx; s0.w = mw;
			end
			OP_NOT: begin
				s0.v = ~av & ~axz; s0.x = axz;
			end
			OP_EQ, OP_NEQ, OP_LT, OP_GT, OP_LTE, OP_GTE: begin
				s0.w = WW'(1);
				s0.x = bad ? '1 : '0;
				case (req.func)
					OP_EQ: s0.v[0] = (av == bv);
					OP_NEQ: s0.v[0] = (av != bv);
					OP_LT: s0.v[0] = (av < bv);
					OP_GT: s0.v[0] = (av > bv);
					OP_LTE: s0.v[0] = (av <= bv);
					default: s0.v[0] = (av >= bv);
				endcase
			end
			OP_LAND: begin
				s0.w = WW'(1);
				if ((!abad && av == '0) || (!bbad && bv == '0)) s0.x = '0;
				else if (bad) s0.x = '1;
				else begin s0.x = '0; s0.v[0] = 1'b1; end
			end
			OP_LOR: begin
				s0.w = WW'(1);
				if ((!abad && av != '0) || (!bbad && bv != '0)) begin
					s0.x = '0; s0.v[0] = 1'b1;
				end else if (bad) s0.x = '1;
				else s0.x = '0;
			end
			OP_LNOT: begin
				s0.w = WW'(1);
				s0.x = abad ? '1 : '0;
				s0.v[0] = (av == '0);
			end
			OP_SHL, OP_SHR, OP_ASHR: begin
				s0.x = bad ? '1 : '0;
				if (bv >= DW'(aw)) begin
					s0.v = (req.func == OP_ASHR && sgn) ? '1 : '0;
				end else if (req.func == OP_SHL) begin
					s0.v = av << sh;
				end else begin
					s0.v = av >> sh;
					if (req.func == OP_ASHR && sgn) s0.v = s0.v | (am & ~(am >> sh));
				end
			end
			OP_ZEXT, OP_SEXT: begin
				// Extensions keep the value plane as it is, even under x or z bits.
				s0.ext = 1'b1;
				s0.v = av; s0.x = ax; s0.z = az;
				if (bw > aw) begin
					s0.w = bw;
					if (req.func == OP_SEXT) begin
						ext = bm & ~am;
						if (av[aw-1]) s0.v = s0.v | ext;
						if (ax[aw-1]) s0.x = s0.x | ext;
						if (az[aw-1]) s0.z = s0.z | ext;
					end
				end
			end
			default: ;
		endcase
		s0.m = wm(s0.w);
	end

	// ---- multiplier: three HW x HW partial products (32x32 by default), then sum
	localparam int HW = (DW + 1) / 2;
	logic [2*HW-1:0] pa_s1, pb_s1, pc_s1;
	logic [DW-1:0] mres_s2;
	logic mul_s1, mul_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s1 <= (2*HW)'(mul_a[HW-1:0]) * (2*HW)'(mul_b[HW-1:0]);
			pb_s1 <= (2*HW)'(mul_a[DW-1:HW]) * (2*HW)'(mul_b[HW-1:0]);
			pc_s1 <= (2*HW)'(mul_a[HW-1:0]) * (2*HW)'(mul_b[DW-1:HW]);
			mul_s1 <= (req.func == OP_MUL);
			mres_s2 <= DW'(pa_s1) + DW'({pb_s1 + pc_s1, {HW{1'b0}}});
			mul_s2 <= mul_s1;
		end
	end

	// ---- divider and side pipeline
	logic [DW-1:0] quo, rem;
	fsa_div #(.DW(DW)) u_div (
		.clk(clk), .en(adv), .num(av), .den(bv), .quo(quo), .rem(rem)
	);

	s1_t side_q [LAT];
	logic [DW-1:0] mulc_q [2:LAT-1];
	logic [LAT-1:2] mulf_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= s0;
			for (int i = 1; i < LAT; i++) side_q[i] <= side_q[i-1];
			mulc_q[2] <= mres_s2;
			mulf_q[2] <= mul_s2;
			for (int i = 3; i < LAT; i++) begin
				mulc_q[i] <= mulc_q[i-1];
				mulf_q[i] <= mulf_q[i-1];
			end
		end
	end

	// ---- output stage
	always_ff @(posedge clk) begin
		s1_t t;
		logic [DW-1:0] v;
		if (adv) begin
			t = side_q[LAT-1];
			v = t.v;
			if (mulf_q[LAT-1]) v = mulc_q[LAT-1];
			if (t.isdiv || t.ismod) begin
				if (t.dbad) begin
					t.x = '1; v = '0;
				end else v = t.isdiv ? quo : rem;
			end
			out_q.r_val <= (t.ext ? v : v & ~t.x) & t.m;
			out_q.r_x <= t.x & t.m;
			out_q.r_z <= t.z & t.m;
			out_q.r_width <= t.w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[LAT-1:0], in.valid};
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |=> out.valid && $stable(out.data))
		else $error("result changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in.ready == (!out.valid || out.ready))
		else $error("input ready does not follow output stage");
	a_width: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid |-> (out_q.r_width != '0 && out_q.r_width <= WW'(DW)))
		else $error("result width out of range");
endmodule

// ===== bench/tb_four_state_alu.sv =====
`timescale 1ns / 1ps
// Self-checking bench for four_state_alu: directed corner items, then bursts of random items.
// Depends on fsa_pkg and fsa_if from the RTL, and on the four_state_alu top level.
module tb_four_state_alu;
	import fsa_pkg::*;

	localparam int IN_W = FW + 6 * 64 + 2 * WW;
	localparam int OUT_W = 3 * 64 + WW;
	localparam int N_RANDOM = 1625;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		bit [FW-1:0] func;
		bit [63:0] a_val, a_x, a_z;
		bit [WW-1:0] a_width;
		bit [63:0] b_val, b_x, b_z;
		bit [WW-1:0] b_width;
	} alu_op_t;

	typedef struct packed {
		bit [63:0] val, x, z;
		bit [WW-1:0] w;
	} fs_word_t;

	function automatic bit [63:0] width_mask(int w);
		return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
	endfunction

	function automatic fs_word_t fs_make(bit [63:0] v, bit [63:0] x, bit [63:0] z, int w);
		fs_word_t r;
		bit [63:0] m;
		m = width_mask(w);
		r.val = v & m;
		r.x = x & m;
		r.z = z & m;
		r.w = w[WW-1:0];
		return r;
	endfunction

	function automatic fs_word_t fs_unknown(int w);
		return fs_make(64'd0, '1, 64'd0, w);
	endfunction

	function automatic int clamp_width(bit [WW-1:0] w);
		if (w == 0) return 1;
		if (w > 64) return 64;
		return int'(w);
	endfunction

	// Truth of an operand: -1 unknown, 0 false, 1 true.
	function automatic int truth_of(fs_word_t a);
		if ((a.x | a.z) != 0) return -1;
		return (a.val != 0) ? 1 : 0;
	endfunction

	function automatic fs_word_t one_bit(int t);
		if (t < 0) return fs_unknown(1);
		return fs_make(t ? 64'd1 : 64'd0, 64'd0, 64'd0, 1);
	endfunction

	function automatic fs_word_t alu_result(alu_op_t it);
		fs_word_t a, b;
		int aw, bw, mw, ta, tb;
		bit [63:0] m, axz, bxz, fixed, rx, r, am, ext, v, x, z;
		bit bad, sign;
		int s;
		aw = clamp_width(it.a_width);
		bw = clamp_width(it.b_width);
		a = fs_make(it.a_val, it.a_x, it.a_z, aw);
		b = fs_make(it.b_val, it.b_x, it.b_z, bw);
		mw = (aw > bw) ? aw : bw;
		m = width_mask(mw);
		axz = a.x | a.z;
		bxz = b.x | b.z;
		bad = (axz | bxz) != 0;
		case (op_t'(it.func))
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
				if (bad) return fs_unknown(mw);
				case (op_t'(it.func))
					OP_ADD: return fs_make(a.val + b.val, 0, 0, mw);
					OP_SUB: return fs_make(a.val - b.val, 0, 0, mw);
					OP_MUL: return fs_make(a.val * b.val, 0, 0, mw);
					default: begin
						if (b.val == 0) return fs_unknown(mw);
						if (op_t'(it.func) == OP_DIV) return fs_make(a.val / b.val, 0, 0, mw);
						return fs_make(a.val % b.val, 0, 0, mw);
					end
				endcase
			end
			OP_NEG: begin
				if (axz != 0) return fs_unknown(aw);
				return fs_make(~a.val + 64'd1, 0, 0, aw);
			end
			OP_AND: begin
				fixed = ((~a.val & ~axz) | (~b.val & ~bxz)) & m;
				rx = (axz | bxz) & ~fixed & m;
				return fs_make(a.val & b.val & ~rx, rx, 0, mw);
			end
			OP_OR: begin
				fixed = ((a.val & ~axz) | (b.val & ~bxz)) & m;
				rx = (axz | bxz) & ~fixed & m;
				return fs_make((a.val | b.val | fixed) & ~rx, rx, 0, mw);
			end
			OP_XOR: begin
				rx = (axz | bxz) & m;
				return fs_make((a.val ^ b.val) & ~rx, rx, 0, mw);
			end
			OP_NOT: return fs_make(~a.val & ~axz, axz, 0, aw);
			OP_EQ, OP_NEQ, OP_LT, OP_GT, OP_LTE, OP_GTE: begin
				if (bad) return fs_unknown(1);
				case (op_t'(it.func))
					OP_EQ: return one_bit(a.val == b.val);
					OP_NEQ: return one_bit(a.val != b.val);
					OP_LT: return one_bit(a.val < b.val);
					OP_GT: return one_bit(a.val > b.val);
					OP_LTE: return one_bit(a.val <= b.val);
					default: return one_bit(a.val >= b.val);
				endcase
			end
			OP_LAND: begin
				ta = truth_of(a);
				tb = truth_of(b);
				if (ta == 0 || tb == 0) return one_bit(0);
				if (ta < 0 || tb < 0) return one_bit(-1);
				return one_bit(1);
			end
			OP_LOR: begin
				ta = truth_of(a);
				tb = truth_of(b);
				if (ta == 1 || tb == 1) return one_bit(1);
				if (ta < 0 || tb < 0) return one_bit(-1);
				return one_bit(0);
			end
			OP_LNOT: begin
				ta = truth_of(a);
				if (ta < 0) return one_bit(-1);
				return one_bit(ta == 0);
			end
			OP_SHL, OP_SHR, OP_ASHR: begin
				am = width_mask(aw);
				sign = a.val[aw-1];
				if (bad) return fs_unknown(aw);
				if (b.val >= aw) begin
					if (op_t'(it.func) == OP_ASHR && sign) return fs_make('1, 0, 0, aw);
					return fs_make(0, 0, 0, aw);
				end
				s = int'(b.val);
				if (op_t'(it.func) == OP_SHL) return fs_make(a.val << s, 0, 0, aw);
				r = a.val >> s;
				if (op_t'(it.func) == OP_ASHR && sign) r |= am & ~(am >> s);
				return fs_make(r, 0, 0, aw);
			end
			OP_ZEXT, OP_SEXT: begin
				if (bw <= aw) return a;
				v = a.val;
				x = a.x;
				z = a.z;
				if (op_t'(it.func) == OP_SEXT) begin
					// The sign bit's three planes each spread into the new upper bits.
					ext = width_mask(bw) & ~width_mask(aw);
					if (a.val[aw-1]) v |= ext;
					if (a.x[aw-1]) x |= ext;
					if (a.z[aw-1]) z |= ext;
				end
				return fs_make(v, x, z, bw);
			end
			default: return fs_unknown(aw);
		endcase
	endfunction

	class alu_scoreboard;
		fs_word_t expected_q[$];
		int mismatches;
		int results_seen;
		int unknown_results;

		function void note_input(alu_op_t it);
			expected_q.push_back(alu_result(it));
		endfunction

		function void check_result(fs_word_t got);
			fs_word_t exp;
			results_seen++;
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: val=%h x=%h", got.val, got.x);
				mismatches++;
				return;
			end
			exp = expected_q.pop_front();
			if (exp.x != 0) unknown_results++;
			if (got.val !== exp.val) begin
				$error("r_val: expected %h, got %h", exp.val, got.val);
				mismatches++;
			end
			if (got.x !== exp.x) begin
				$error("r_x: expected %h, got %h", exp.x, got.x);
				mismatches++;
			end
			if (got.z !== exp.z) begin
				$error("r_z: expected %h, got %h", exp.z, got.z);
				mismatches++;
			end
			if (got.w !== exp.w) begin
				$error("r_width: expected %0d, got %0d", exp.w, got.w);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	fsa_if #(.W(IN_W)) op_ch ();
	fsa_if #(.W(OUT_W)) res_ch ();
	alu_scoreboard board;
	int cycles;
	int accepted;
	bit hold_done;

	four_state_alu u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in(op_ch),
		.out(res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("four_state_alu verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) board.check_result(fs_word_t'(res_ch.data));
	end

	// Receiver: stall density is redrawn as the run goes on, with some stretches stall-free,
	// and one long hold-off once the run is under way so the pipeline backs up.
	initial begin
		int hold;
		int density;
		hold = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (cycles % 256 == 0) density = $urandom_range(0, 3) * 25;
			if (!hold_done && accepted >= 400) begin
				hold_done = 1;
				hold = 300;
			end
			if (hold > 0) begin
				hold--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= density);
			end
		end
	end

	task automatic send_op(alu_op_t it);
		@(negedge clk);
		op_ch.valid <= 1'b1;
		op_ch.data <= it;
		do @(posedge clk); while (!op_ch.ready);
		board.note_input(it);
		accepted++;
	endtask

	task automatic pause_sender(int n);
		@(negedge clk);
		op_ch.valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_fields(bit [4:0] f, bit [63:0] av, bit [63:0] ax, bit [63:0] az,
			bit [6:0] aw, bit [63:0] bv, bit [63:0] bx, bit [63:0] bz, bit [6:0] bw);
		alu_op_t it;
		it = '{f, av, ax, az, aw, bv, bx, bz, bw};
		send_op(it);
	endtask

	function automatic bit [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Unknown masks: mostly clean so arithmetic gets exercised, sometimes sparse or dense.
	function automatic bit [63:0] rand_mask();
		case ($urandom_range(0, 9))
			0: return rand64();
			1, 2: return 64'd1 << $urandom_range(0, 63);
			default: return 64'd0;
		endcase
	endfunction

	function automatic bit [6:0] rand_width();
		case ($urandom_range(0, 9))
			0: return 7'($urandom_range(0, 127));
			1: return 7'd64;
			2, 3: return 7'($urandom_range(1, 8));
			default: return 7'($urandom_range(1, 64));
		endcase
	endfunction

	function automatic alu_op_t rand_op();
		alu_op_t it;
		it.func = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(24, 31))
			: 5'($urandom_range(OP_ADD, OP_SEXT));
		it.a_val = rand64();
		it.a_x = rand_mask();
		it.a_z = rand_mask();
		it.a_width = rand_width();
		it.b_val = rand64();
		it.b_x = rand_mask();
		it.b_z = rand_mask();
		it.b_width = rand_width();
		case ($urandom_range(0, 7))
			0: it.b_val = it.a_val;
			1: it.b_val = 64'($urandom_range(0, 70));
			2: it.b_val = 64'd0;
			default: ;
		endcase
		return it;
	endfunction

	initial begin
		int burst;
		int sent;
		board = new();
		cycles = 0;
		accepted = 0;
		hold_done = 0;
		arst_n = 1'b0;
		op_ch.valid = 1'b0;
		op_ch.data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_fields(OP_ADD, '1, 0, 0, 64, 64'd1, 0, 0, 64);
		send_fields(OP_SUB, 0, 0, 0, 7'd0, 64'd1, 0, 0, 7'd127);
		send_fields(OP_MUL, '1, 0, 0, 64, '1, 0, 0, 64);
		send_fields(OP_DIV, 64'd100, 0, 0, 32, 64'd0, 0, 0, 8);
		send_fields(OP_MOD, 64'd100, 0, 0, 32, 64'd7, 0, 0, 8);
		send_fields(OP_DIV, 64'd100, 64'd4, 0, 32, 64'd7, 0, 0, 8);
		send_fields(OP_NEG, 64'd5, 0, 0, 8, 0, 0, 0, 1);
		send_fields(OP_AND, 64'h0f, 64'hf0, 64'h0f00, 16, 64'hff, 0, 0, 12);
		send_fields(OP_OR, 64'h0f, 64'hf0, 64'h0f00, 16, 64'h0f0, 0, 64'hf, 12);
		send_fields(OP_XOR, '1, 64'h3, 0, 64, 64'h5a, 0, 64'h80, 8);
		send_fields(OP_NOT, 64'h5, 64'h2, 64'h8, 4, 0, 0, 0, 1);
		send_fields(OP_EQ, 64'd9, 0, 0, 64, 64'd9, 0, 0, 64);
		send_fields(OP_NEQ, 64'd9, 0, 64'd1, 64, 64'd9, 0, 0, 64);
		send_fields(OP_LT, 64'd3, 0, 0, 4, 64'd4, 0, 0, 4);
		send_fields(OP_GT, 64'd3, 0, 0, 4, 64'd4, 0, 0, 4);
		send_fields(OP_LTE, 64'd4, 0, 0, 4, 64'd4, 0, 0, 4);
		send_fields(OP_GTE, 64'd4, 0, 0, 4, 64'd5, 0, 0, 4);
		send_fields(OP_LAND, 64'd0, 0, 0, 4, 0, 64'd1, 0, 4);
		send_fields(OP_LOR, 64'd2, 0, 0, 4, 0, 0, 64'd1, 4);
		send_fields(OP_LNOT, 64'd0, 64'd1, 0, 4, 0, 0, 0, 4);
		send_fields(OP_SHL, 64'h81, 0, 0, 8, 64'd3, 0, 0, 8);
		send_fields(OP_SHR, 64'h81, 0, 0, 8, 64'd8, 0, 0, 8);
		send_fields(OP_ASHR, 64'h81, 0, 0, 8, 64'd3, 0, 0, 8);
		send_fields(OP_ASHR, 64'h81, 0, 0, 8, 64'd200, 0, 0, 8);
		send_fields(OP_ZEXT, 64'h8, 64'h1, 0, 4, 0, 0, 0, 12);
		send_fields(OP_SEXT, 64'h0, 0, 64'h8, 4, 0, 0, 0, 64);
		send_fields(OP_SEXT, 64'hf, 0, 0, 12, 0, 0, 0, 4);
		send_fields(5'd31, '1, '1, '1, 7'd127, '1, '1, '1, 7'd127);

		sent = 0;
		while (sent < N_RANDOM) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst && sent < N_RANDOM; i++) begin
				send_op(rand_op());
				sent++;
			end
			if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
		end
		pause_sender(1);

		while (board.pending() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		$display("Ran %0d items over all %0d operations plus unused codes; %0d results checked,",
			accepted, OP_SEXT + 1, board.results_seen);
		$display("%0d of them carrying unknown bits, with one long output hold-off.",
			board.unknown_results);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("four_state_alu verification clean");
		end else begin
			$display("four_state_alu verification failed");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
src/fsa_pkg.sv
src/fsa_if.sv
src/fsa_div.sv
src/four_state_alu.sv
bench/tb_four_state_alu.sv
